// File: src/svpd_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the SPI video packet deframer.
// No dependencies; every other file imports this package.
package svpd_pkg;

    // Packet and frame geometry
    localparam logic [7:0] PACKET_BYTES      = 8'd164;
    localparam logic [7:0] HEADER_BYTES      = 8'd4;
    localparam int         PACKETS_PER_IMAGE = 60;
    // Packet number that closes the frame, in the 6-bit packet counter
    localparam logic [5:0] FRAME_END_PACKET  = 6'(PACKETS_PER_IMAGE);

    // Configuration reset values
    localparam logic [31:0] TIMEOUT_TICKS_RESET = 32'd1000000;
    localparam logic [15:0] RESYNC_LIMIT_RESET  = 16'd750;

    // Result queue depth, counted in result pairs
    localparam int RQ_DEPTH   = 2;
    localparam int RQ_PTR_W   = $clog2(RQ_DEPTH);
    localparam int RQ_COUNT_W = $clog2(RQ_DEPTH + 1);

    typedef enum logic [1:0] {
        ACT_START = 2'd0,
        ACT_BYTE  = 2'd1,
        ACT_TICK  = 2'd2
    } t_action;

    typedef enum logic [1:0] {
        KIND_PIXEL      = 2'd0,
        KIND_FRAME_DONE = 2'd1,
        KIND_TIMEOUT    = 2'd2,
        KIND_LINK_RESET = 2'd3
    } t_kind;

    typedef enum logic {
        CFG_TIMEOUT_TICKS = 1'b0,
        CFG_RESYNC_LIMIT  = 1'b1
    } t_cfg_index;

    typedef struct packed {
        t_kind       kind;
        logic [15:0] pixel;
        logic [5:0]  row;
        logic [6:0]  column;
        logic        last;
    } t_result;

    // Up to two results caused by one item; first is always used
    typedef struct packed {
        logic    two;
        t_result first;
        t_result second;
    } t_res_pair;

    typedef struct packed {
        logic      valid;
        t_res_pair pair;
    } t_push;

endpackage

// File: src/svpd_if.sv
`timescale 1ns / 1ps
// Channel interfaces: input items, result items and configuration writes.
// Depends on svpd_pkg.
interface svpd_in_if;
    import svpd_pkg::*;
    logic       valid;
    logic       ready;
    logic [1:0] action;
    logic [7:0] data_byte;

    modport source (output valid, output action, output data_byte, input ready);
    modport sink   (input valid, input action, input data_byte, output ready);
endinterface

interface svpd_out_if;
    import svpd_pkg::*;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [15:0] pixel;
    logic [5:0]  row;
    logic [6:0]  column;
    logic        last;

    modport source (output valid, output kind, output pixel, output row,
                    output column, output last, input ready);
    modport sink   (input valid, input kind, input pixel, input row,
                    input column, input last, output ready);
endinterface

interface svpd_cfg_if;
    import svpd_pkg::*;
    logic        valid;
    logic        ready;
    logic        index;
    logic [31:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: src/svpd_rq.sv
`timescale 1ns / 1ps
// Result queue: holds result pairs and hands them out one item at a time.
// Depends on svpd_pkg and svpd_out_if.
module svpd_rq (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  svpd_pkg::t_push    i_push,
    output logic               o_room,
    svpd_out_if.source         o_res
);
    import svpd_pkg::*;

    t_res_pair               r_entry [RQ_DEPTH];
    logic [RQ_PTR_W-1:0]     r_wr, r_rd;
    logic [RQ_COUNT_W-1:0]   r_count;
    logic                    r_half;
    t_result                 head;
    logic                    out_take;
    logic                    pop;

    // Room only depends on registered state, so no path from output ready
    assign o_room = (r_count != RQ_COUNT_W'(RQ_DEPTH));

    assign head     = r_half ? r_entry[r_rd].second : r_entry[r_rd].first;
    assign out_take = o_res.valid && o_res.ready;
    assign pop      = out_take && (r_half || !r_entry[r_rd].two);

    assign o_res.valid  = (r_count != '0);
    assign o_res.kind   = head.kind;
    assign o_res.pixel  = head.pixel;
    assign o_res.row    = head.row;
    assign o_res.column = head.column;
    assign o_res.last   = head.last;

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_entry[r_wr] <= i_push.pair;
        end
    end

    // Pointers, fill count and half select
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
            r_half  <= 1'b0;
        end else begin
            if (i_push.valid) begin
                r_wr <= RQ_PTR_W'((32'(r_wr) + 1) % RQ_DEPTH);
            end
            if (pop) begin
                r_rd   <= RQ_PTR_W'((32'(r_rd) + 1) % RQ_DEPTH);
                r_half <= 1'b0;
            end else if (out_take) begin
                r_half <= 1'b1;
            end
            r_count <= r_count + RQ_COUNT_W'(i_push.valid) - RQ_COUNT_W'(pop);
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= RQ_COUNT_W'(RQ_DEPTH))
        else $error("result queue overfilled");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push.valid && (r_count == RQ_COUNT_W'(RQ_DEPTH)) && !pop))
        else $error("push into full result queue");

    a_half_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_half |-> ((r_count != '0) && r_entry[r_rd].two))
        else $error("second half selected on single-result entry");
`endif

endmodule

// File: src/svpd_ctl.sv
`timescale 1ns / 1ps
// Deframer control: input register, frame tracking state and result generation.
// Depends on svpd_pkg and svpd_in_if.
module svpd_ctl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    svpd_in_if.sink            i_item,
    input  logic [31:0]        i_timeout_ticks,
    input  logic [15:0]        i_resync_limit,
    input  logic               i_room,
    output svpd_pkg::t_push    o_push
);
    import svpd_pkg::*;

    // Input register
    logic        r_in_valid;
    t_action     r_in_action;
    logic [7:0]  r_in_byte;

    // Frame tracking state
    logic        r_capturing, n_capturing;
    logic [7:0]  r_byte_pos, n_byte_pos;
    logic [5:0]  r_expected, n_expected;
    logic        r_dropped, n_dropped;
    logic [7:0]  r_hold, n_hold;
    logic [15:0] r_resync, n_resync;
    logic [31:0] r_elapsed, n_elapsed;

    logic        advance;
    logic        drop_now;
    logic [7:0]  offset;
    logic [5:0]  exp_inc;
    logic [15:0] resync_inc;
    logic [31:0] elapsed_inc;
    t_result     res_a, res_b;
    logic        has_a, has_b;

    assign advance      = r_in_valid && i_room;
    assign i_item.ready = !r_in_valid || advance;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_item.ready) begin
            r_in_valid <= i_item.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_item.ready && i_item.valid) begin
            r_in_action <= t_action'(i_item.action);
            r_in_byte   <= i_item.data_byte;
        end
    end

    assign offset      = r_byte_pos - HEADER_BYTES;
    assign exp_inc     = r_expected + 6'd1;
    assign resync_inc  = r_resync + 16'd1;
    assign elapsed_inc = (r_elapsed == '1) ? r_elapsed : r_elapsed + 32'd1;
    assign drop_now    = !r_dropped && (r_byte_pos == 8'd1)
                         && (r_in_byte != {2'b00, r_expected});

    // Next state and results for the registered item
    always_comb begin
        n_capturing = r_capturing;
        n_byte_pos  = r_byte_pos;
        n_expected  = r_expected;
        n_dropped   = r_dropped;
        n_hold      = r_hold;
        n_resync    = r_resync;
        n_elapsed   = r_elapsed;
        has_a       = 1'b0;
        has_b       = 1'b0;
        res_a       = '0;
        res_b       = '0;

        unique case (r_in_action)
            ACT_START: begin
                n_capturing = 1'b1;
                n_byte_pos  = '0;
                n_expected  = '0;
                n_dropped   = 1'b0;
                n_hold      = '0;
                n_resync    = '0;
                n_elapsed   = '0;
            end
            ACT_TICK: begin
                if (r_capturing) begin
                    n_elapsed = elapsed_inc;
                    if (elapsed_inc > i_timeout_ticks) begin
                        n_capturing = 1'b0;
                        has_a       = 1'b1;
                        res_a.kind  = KIND_TIMEOUT;
                    end
                end
            end
            ACT_BYTE: begin
                if (r_capturing) begin
                    // Header check and payload pairing
                    if (drop_now) begin
                        n_dropped  = 1'b1;
                        n_expected = '0;
                        if (r_resync != '1) begin
                            n_resync = resync_inc;
                            if (resync_inc == i_resync_limit) begin
                                has_a      = 1'b1;
                                res_a.kind = KIND_LINK_RESET;
                            end
                        end
                    end else if (!r_dropped && (r_byte_pos >= HEADER_BYTES)) begin
                        if (!offset[0]) begin
                            n_hold = r_in_byte;
                        end else begin
                            has_a        = 1'b1;
                            res_a.kind   = KIND_PIXEL;
                            res_a.pixel  = {r_hold, r_in_byte};
                            res_a.row    = r_expected;
                            res_a.column = offset[7:1];
                        end
                    end
                    // End of packet
                    if (r_byte_pos >= PACKET_BYTES - 8'd1) begin
                        n_byte_pos = '0;
                        if (r_dropped || drop_now) begin
                            n_dropped = 1'b0;
                        end else if (exp_inc == FRAME_END_PACKET) begin
                            n_capturing = 1'b0;
                            n_expected  = '0;
                            has_b       = 1'b1;
                            res_b.kind  = KIND_FRAME_DONE;
                        end else begin
                            n_expected = exp_inc;
                        end
                    end else begin
                        n_byte_pos = r_byte_pos + 8'd1;
                    end
                end
            end
            default: begin
                // undefined action: no effect
            end
        endcase
    end

    // Pack results: the first present result leads, last flags the final one
    always_comb begin
        o_push = '0;
        o_push.valid = advance && (has_a || has_b);
        if (has_a) begin
            o_push.pair.first        = res_a;
            o_push.pair.two          = has_b;
            o_push.pair.second       = res_b;
            o_push.pair.first.last   = !has_b;
            o_push.pair.second.last  = 1'b1;
        end else begin
            o_push.pair.first        = res_b;
            o_push.pair.first.last   = 1'b1;
        end
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capturing <= 1'b0;
            r_byte_pos  <= '0;
            r_expected  <= '0;
            r_dropped   <= 1'b0;
            r_hold      <= '0;
            r_resync    <= '0;
            r_elapsed   <= '0;
        end else if (advance) begin
            r_capturing <= n_capturing;
            r_byte_pos  <= n_byte_pos;
            r_expected  <= n_expected;
            r_dropped   <= n_dropped;
            r_hold      <= n_hold;
            r_resync    <= n_resync;
            r_elapsed   <= n_elapsed;
        end
    end

`ifndef SYNTHESIS
    a_pair_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push.valid && o_push.pair.two) |->
        ((o_push.pair.first.kind == KIND_PIXEL)
         && (o_push.pair.second.kind == KIND_FRAME_DONE)))
        else $error("two results other than pixel then frame done");

    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_byte_pos < PACKET_BYTES)
        else $error("byte position past packet end");

    a_idle_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push.valid && !r_capturing) |-> 1'b0)
        else $error("result while not capturing");
`endif

endmodule

// File: src/spi_video_packet_deframer_core.sv
`timescale 1ns / 1ps
// Path: each accepted item waits in the input register; its results are written
// to the result queue, which presents them on the output channel.
// Throughput: one item per cycle while the two-pair result queue has room; an
// item giving two results (last pixel plus frame done) leaves it one at a time.
// Reset: synchronous, active low; clears all frame state and the queue and
// loads timeout_ticks = 1000000 and resync_limit = 750.
module spi_video_packet_deframer_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    svpd_in_if.sink     i_item,
    svpd_out_if.source  o_res,
    svpd_cfg_if.sink    i_cfg
);
    import svpd_pkg::*;

    logic [31:0] r_timeout_ticks;
    logic [15:0] r_resync_limit;
    logic        room;
    t_push       push;

    assign i_cfg.ready = 1'b1;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout_ticks <= TIMEOUT_TICKS_RESET;
            r_resync_limit  <= RESYNC_LIMIT_RESET;
        end else if (i_cfg.valid) begin
            unique case (t_cfg_index'(i_cfg.index))
                CFG_TIMEOUT_TICKS: r_timeout_ticks <= i_cfg.data;
                CFG_RESYNC_LIMIT:  r_resync_limit  <= i_cfg.data[15:0];
                default: begin
                end
            endcase
        end
    end

    svpd_ctl u_ctl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_item          (i_item),
        .i_timeout_ticks (r_timeout_ticks),
        .i_resync_limit  (r_resync_limit),
        .i_room          (room),
        .o_push          (push)
    );

    svpd_rq u_rq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (room),
        .o_res   (o_res)
    );

endmodule

// File: bench/spi_video_packet_deframer_checker.sv
`timescale 1ns / 1ps
// Checker for the SPI video packet deframer: watches the item, result and
// register channels, predicts every result and compares it field by field.
// Depends on svpd_pkg.
module spi_video_packet_deframer_checker
    import svpd_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_in_ready,
    input  logic [1:0]       i_in_action,
    input  logic [7:0]       i_in_data_byte,
    input  logic             i_out_valid,
    input  logic             i_out_ready,
    input  logic [1:0]       i_out_kind,
    input  logic [15:0]      i_out_pixel,
    input  logic [5:0]       i_out_row,
    input  logic [6:0]       i_out_column,
    input  logic             i_out_last,
    input  logic             i_cfg_valid,
    input  logic             i_cfg_ready,
    input  logic             i_cfg_index,
    input  logic [31:0]      i_cfg_data,
    output int               o_fail_count,
    output int               o_pending,
    output logic [3:0][31:0] o_kind_count
);

    // Register copies
    logic [31:0] timeout_reg;
    logic [15:0] resync_limit_reg;

    // Deframer state
    logic        cap_active;
    logic [7:0]  byte_pos;
    logic [5:0]  next_packet;
    logic        drop_rest;
    logic [7:0]  high_byte;
    logic [15:0] resync_cnt;
    logic [31:0] tick_cnt;

    // Results still owed by the block, oldest first
    t_result outbound_events[$];

    function automatic t_result result_of(t_kind kind, logic [15:0] pixel,
                                          logic [5:0] row, logic [6:0] column);
        t_result res;
        res.kind   = kind;
        res.pixel  = pixel;
        res.row    = row;
        res.column = column;
        res.last   = 1'b0;
        return res;
    endfunction

    // Advance the deframer by one item and queue what it emits
    task automatic deframe_item(input logic [1:0] act, input logic [7:0] b);
        t_result    evs [2];
        int         n;
        logic [7:0] off;
        n = 0;
        if (act == ACT_START) begin
            cap_active  = 1'b1;
            byte_pos    = '0;
            next_packet = '0;
            drop_rest   = 1'b0;
            high_byte   = '0;
            resync_cnt  = '0;
            tick_cnt    = '0;
        end else if (cap_active && act == ACT_TICK) begin
            if (tick_cnt != 32'hFFFF_FFFF)
                tick_cnt = tick_cnt + 32'd1;
            if (tick_cnt > timeout_reg) begin
                cap_active = 1'b0;
                evs[n] = result_of(KIND_TIMEOUT, '0, '0, '0);
                n++;
            end
        end else if (cap_active && act == ACT_BYTE) begin
            if (!drop_rest) begin
                if (byte_pos == 8'd1 && b != {2'b00, next_packet}) begin
                    // packet number out of sequence: drop it, restart frame
                    drop_rest   = 1'b1;
                    next_packet = '0;
                    if (resync_cnt != 16'hFFFF) begin
                        resync_cnt = resync_cnt + 16'd1;
                        if (resync_cnt == resync_limit_reg) begin
                            evs[n] = result_of(KIND_LINK_RESET, '0, '0, '0);
                            n++;
                        end
                    end
                end else if (byte_pos >= HEADER_BYTES) begin
                    off = byte_pos - HEADER_BYTES;
                    if (!off[0]) begin
                        high_byte = b;
                    end else begin
                        evs[n] = result_of(KIND_PIXEL, {high_byte, b}, next_packet,
                                           off[7:1]);
                        n++;
                    end
                end
            end
            // end of packet
            if ({1'b0, byte_pos} + 9'd1 >= {1'b0, PACKET_BYTES}) begin
                byte_pos = '0;
                if (drop_rest) begin
                    drop_rest = 1'b0;
                end else begin
                    next_packet = next_packet + 6'd1;
                    if (next_packet == FRAME_END_PACKET) begin
                        cap_active  = 1'b0;
                        next_packet = '0;
                        evs[n] = result_of(KIND_FRAME_DONE, '0, '0, '0);
                        n++;
                    end
                end
            end else begin
                byte_pos = byte_pos + 8'd1;
            end
        end
        if (n > 0)
            evs[n-1].last = 1'b1;
        for (int i = 0; i < n; i++)
            outbound_events.push_back(evs[i]);
    endtask

    function automatic void check_field(input string field_name,
                                        input logic [15:0] want_v,
                                        input logic [15:0] got_v);
        if (got_v !== want_v) begin
            $error("%s mismatch: expected %0d, got %0d", field_name, want_v, got_v);
            o_fail_count++;
        end
    endfunction

    always @(posedge i_clk) begin : watch
        t_result want;
        if (!i_rst_n) begin
            timeout_reg      = TIMEOUT_TICKS_RESET;
            resync_limit_reg = RESYNC_LIMIT_RESET;
            cap_active       = 1'b0;
            byte_pos         = '0;
            next_packet      = '0;
            drop_rest        = 1'b0;
            high_byte        = '0;
            resync_cnt       = '0;
            tick_cnt         = '0;
            o_fail_count     = 0;
            o_kind_count     = '0;
            outbound_events.delete();
        end else begin
            // register writes
            if (i_cfg_valid && i_cfg_ready) begin
                case (t_cfg_index'(i_cfg_index))
                    CFG_TIMEOUT_TICKS: timeout_reg = i_cfg_data;
                    CFG_RESYNC_LIMIT:  resync_limit_reg = i_cfg_data[15:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready)
                deframe_item(i_in_action, i_in_data_byte);
            // compare each result against the oldest prediction
            if (i_out_valid && i_out_ready) begin
                if (outbound_events.size() == 0) begin
                    $error("unexpected result: kind %0d pixel %0d row %0d column %0d",
                           i_out_kind, i_out_pixel, i_out_row, i_out_column);
                    o_fail_count++;
                end else begin
                    want = outbound_events.pop_front();
                    check_field("kind", 16'(want.kind), 16'(i_out_kind));
                    check_field("pixel", want.pixel, i_out_pixel);
                    check_field("row", 16'(want.row), 16'(i_out_row));
                    check_field("column", 16'(want.column), 16'(i_out_column));
                    check_field("last", 16'(want.last), 16'(i_out_last));
                end
                o_kind_count[i_out_kind] = o_kind_count[i_out_kind] + 1;
            end
        end
        o_pending <= outbound_events.size();
    end

endmodule

// File: bench/spi_video_packet_deframer_core_tb.sv
`timescale 1ns / 1ps
// Testbench top for spi_video_packet_deframer_core: drives items and register
// writes, paces the result side, and reports the verdict.
// Depends on svpd_pkg, the svpd channel interfaces and the checker module.
module spi_video_packet_deframer_core_tb;
    import svpd_pkg::*;

    localparam int         HALF_PERIOD    = 6;
    localparam int         RESET_CYCLES   = 10;
    localparam int         SETTLE_CYCLES  = 8;
    localparam int         WATCHDOG_LIMIT = 2000;
    localparam int         RANDOM_ITEMS   = 160;   // per random phase, four phases
    localparam logic [1:0] ACT_RESERVED   = 2'd3;

    typedef enum int {
        PACE_BUSY,
        PACE_LIGHT,
        PACE_OFF
    } t_pace;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    t_pace src_pace = PACE_BUSY;
    t_pace snk_pace = PACE_BUSY;
    int    sink_hold;
    int    quiet_cycles;
    int    items_sent;
    int    settings_used;

    int               fail_count;
    int               pending;
    logic [3:0][31:0] kind_count;

    svpd_in_if  item_ch ();
    svpd_out_if res_ch ();
    svpd_cfg_if cfg_ch ();

    spi_video_packet_deframer_core i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_item  (item_ch),
        .o_res   (res_ch),
        .i_cfg   (cfg_ch)
    );

    spi_video_packet_deframer_checker u_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (item_ch.valid),
        .i_in_ready     (item_ch.ready),
        .i_in_action    (item_ch.action),
        .i_in_data_byte (item_ch.data_byte),
        .i_out_valid    (res_ch.valid),
        .i_out_ready    (res_ch.ready),
        .i_out_kind     (res_ch.kind),
        .i_out_pixel    (res_ch.pixel),
        .i_out_row      (res_ch.row),
        .i_out_column   (res_ch.column),
        .i_out_last     (res_ch.last),
        .i_cfg_valid    (cfg_ch.valid),
        .i_cfg_ready    (cfg_ch.ready),
        .i_cfg_index    (cfg_ch.index),
        .i_cfg_data     (cfg_ch.data),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_kind_count   (kind_count)
    );

    always #(HALF_PERIOD) clk = ~clk;

    function automatic int draw_wait(input t_pace pace);
        case (pace)
            PACE_BUSY:  return $urandom_range(0, 16);
            PACE_LIGHT: return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 16) : 0;
            default:    return 0;
        endcase
    endfunction

    function automatic t_pace pick_pace();
        case ($urandom_range(0, 3))
            0, 1:    return PACE_BUSY;
            2:       return PACE_LIGHT;
            default: return PACE_OFF;
        endcase
    endfunction

    // Result side: may stall after each result, and now and then while idle
    always @(posedge clk) begin : result_sink
        if (!rst_n) begin
            sink_hold = 0;
            res_ch.ready <= 1'b0;
        end else begin
            if (res_ch.valid && res_ch.ready)
                sink_hold = draw_wait(snk_pace);
            else if (sink_hold > 0)
                sink_hold = sink_hold - 1;
            else if (!res_ch.valid && $urandom_range(0, 15) == 0)
                sink_hold = draw_wait(snk_pace);
            res_ch.ready <= (sink_hold == 0);
        end
    end

    // Watchdog: nothing moving on any channel for too long
    always @(posedge clk) begin : watchdog
        if (!rst_n || (item_ch.valid && item_ch.ready) || (res_ch.valid && res_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready))
            quiet_cycles = 0;
        else
            quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("Watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // One item on the input channel; valid stays high for a back-to-back item
    task automatic send_item(input logic [1:0] act, input logic [7:0] b);
        int gap;
        gap = draw_wait(src_pace);
        if (gap > 0) begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_ch.valid     <= 1'b1;
        item_ch.action    <= act;
        item_ch.data_byte <= b;
        do @(posedge clk); while (!item_ch.ready);
        items_sent++;
    endtask

    // Drain all owed results, then give the pipeline time to empty
    task automatic settle();
        item_ch.valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic put_reg(input t_cfg_index idx, input logic [31:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do @(posedge clk); while (!cfg_ch.ready);
    endtask

    task automatic program_regs(input logic [31:0] ticks, input logic [15:0] limit);
        settle();
        put_reg(CFG_TIMEOUT_TICKS, ticks);
        put_reg(CFG_RESYNC_LIMIT, {16'd0, limit});
        cfg_ch.valid <= 1'b0;
        settings_used++;
    endtask

    // One packet; a spoiled one carries a wrong packet number
    task automatic send_packet(input logic [5:0] num, input bit spoil, input int tick_pct);
        logic [7:0] b;
        for (int i = 0; i < int'(PACKET_BYTES); i++) begin
            if ($urandom_range(0, 99) < tick_pct)
                send_item(ACT_TICK, 8'($urandom));
            if ($urandom_range(0, 199) == 0)
                send_item(ACT_RESERVED, 8'($urandom));
            if (i == 1 && !spoil)
                b = {2'b00, num};
            else if (i == 1)
                do b = 8'($urandom); while (b == {2'b00, num});
            else
                b = 8'($urandom);
            send_item(ACT_BYTE, b);
        end
    endtask

    // Start, then packets in sequence until goal good packets in a row
    task automatic capture_frame(input int goal, input int spoil_pct, input int tick_pct,
                                 input int max_spoils);
        int good;
        int spoils;
        bit spoil;
        good   = 0;
        spoils = 0;
        send_item(ACT_START, 8'($urandom));
        while (good < goal) begin
            spoil = (spoils < max_spoils) && ($urandom_range(0, 99) < spoil_pct);
            send_packet(6'(good), spoil, tick_pct);
            if (spoil) begin
                good = 0;
                spoils++;
            end else begin
                good++;
            end
        end
    endtask

    // Mix of partial frames, short header bursts and plain noise
    task automatic random_phase(input int n_items, input int tick_pct);
        int stop_at;
        int r;
        int pick;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at) begin
            src_pace = pick_pace();
            snk_pace = pick_pace();
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
                capture_frame($urandom_range(1, 2), 25, tick_pct, 3);
            end else if (pick < 75) begin
                send_item(ACT_START, 8'($urandom));
                repeat ($urandom_range(2, 12)) begin
                    r = $urandom_range(0, 99);
                    if (r < 80)
                        send_item(ACT_BYTE, $urandom_range(0, 1) ? 8'd0 : 8'($urandom));
                    else if (r < 95)
                        send_item(ACT_TICK, 8'($urandom));
                    else
                        send_item(ACT_RESERVED, 8'($urandom));
                end
            end else begin
                repeat ($urandom_range(5, 20))
                    send_item(2'($urandom), 8'($urandom));
            end
        end
    endtask

    initial begin : stimulus
        item_ch.valid     <= 1'b0;
        item_ch.action    <= ACT_START;
        item_ch.data_byte <= 8'd0;
        cfg_ch.valid      <= 1'b0;
        cfg_ch.index      <= CFG_TIMEOUT_TICKS;
        cfg_ch.data       <= 32'd0;
        items_sent    = 0;
        settings_used = 0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: zero timeout, resync limit of one
        program_regs(32'd0, 16'd1);
        send_item(ACT_BYTE, 8'hAA);         // idle: ignored
        send_item(ACT_TICK, 8'h55);         // idle: ignored
        send_item(ACT_RESERVED, 8'hFF);     // reserved action: ignored
        send_item(ACT_START, 8'h00);
        send_item(ACT_BYTE, 8'h00);
        send_item(ACT_BYTE, 8'h00);         // packet 0, in sequence
        send_item(ACT_BYTE, 8'hFF);
        send_item(ACT_BYTE, 8'hFF);
        send_item(ACT_BYTE, 8'hFF);
        send_item(ACT_BYTE, 8'h00);         // pixel ff00, column 0
        send_item(ACT_BYTE, 8'h00);
        send_item(ACT_BYTE, 8'hFF);         // pixel 00ff, column 1
        send_item(ACT_RESERVED, 8'h00);
        send_item(ACT_START, 8'hFF);        // restart while capturing
        send_item(ACT_BYTE, 8'h12);
        send_item(ACT_BYTE, 8'hC0);         // wrong number: resync hits the limit
        send_item(ACT_BYTE, 8'h55);         // dropped
        send_item(ACT_TICK, 8'h00);         // first tick times out
        send_item(ACT_BYTE, 8'h33);         // idle again: ignored

        // Directed: largest register values
        program_regs(32'hFFFF_FFFF, 16'hFFFF);
        send_item(ACT_START, 8'h00);
        send_item(ACT_TICK, 8'hFF);
        send_item(ACT_BYTE, 8'h00);
        send_item(ACT_BYTE, 8'h40);         // upper bits set: still a mismatch

        // Random phases under several register settings
        program_regs(32'd40, 16'd2);
        random_phase(RANDOM_ITEMS, 3);
        program_regs(32'd3, 16'd1);
        random_phase(RANDOM_ITEMS, 1);
        program_regs(32'hFFFF_FFFF, 16'd3);
        random_phase(RANDOM_ITEMS, 3);
        program_regs(32'd12, 16'hFFFF);
        random_phase(RANDOM_ITEMS, 2);

        settle();
        $display("Run covered %0d input items under %0d register settings.",
                 items_sent, settings_used);
        $display("Results: %0d pixels, %0d frames done, %0d timeouts, %0d link resets.",
                 kind_count[KIND_PIXEL], kind_count[KIND_FRAME_DONE],
                 kind_count[KIND_TIMEOUT], kind_count[KIND_LINK_RESET]);
        if (fail_count == 0 && pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
